// File: hdl/abd_pkg.sv
// ----------------------------------------------------------------------------
// abd_pkg
// Shared widths, register indexes and reset values of the audio beat detector.
// ----------------------------------------------------------------------------
package abd_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int LEVEL_W    = 12;
    localparam int HOLD_W     = 16;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int HIST_W     = 32;

    localparam int ADC_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DC_OFFSET  = 3'd0,
        CFG_BEAT_THR   = 3'd1,
        CFG_PEAK_LEVEL = 3'd2,
        CFG_BEAT_HOLD  = 3'd3,
        CFG_DECAY_HOLD = 3'd4
    } t_cfg_idx;

    localparam logic [SAMPLE_W-1:0] DC_OFFSET_RST  = 12'd1024;
    localparam logic [THR_W-1:0]    BEAT_THR_RST   = 16'd35;
    localparam logic [LEVEL_W-1:0]  PEAK_LEVEL_RST = 12'd1024;
    localparam logic [HOLD_W-1:0]   BEAT_HOLD_RST  = 16'd125;
    localparam logic [HOLD_W-1:0]   DECAY_HOLD_RST = 16'd50;

endpackage

// File: hdl/audio_beat_detector.sv
// ----------------------------------------------------------------------------
// audio_beat_detector
// Bass bandpass IIR filter on microphone samples with beat and decay tracking.
// ----------------------------------------------------------------------------
// Each input item carries one raw ADC sample and a restart flag. The sample is
// offset-corrected, scaled, filtered by a second-order bandpass and compared
// against the beat threshold. A beat loads the peak level; otherwise a nonzero
// intensity decays by one. Each item yields at most one result item, with the
// new intensity, the beat flag and the hold time; a decay at zero intensity
// yields none.
// The block has three register stages: input capture, input scaling, and the
// filter recursion with the decision, which writes the result register. A
// result passes through the capture, scaling and result registers in turn, and
// one item is taken per cycle while the receiver does not stall. The recursion
// stage holds the multiply-adds on the two past outputs.
// While the receiver stalls, the result register holds; items already in the
// pipe move up into empty stages, and o_stall rises once all stages are full.
// Reset empties the pipe, clears the filter history and intensity and loads the
// register defaults; items are taken from the next cycle on. Configuration
// writes take effect at once and must be made only while idle (not enforced).
module audio_beat_detector
    import abd_pkg::*;
#(
    parameter int ADC_BITS  = ADC_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_restart,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [LEVEL_W-1:0]    o_intensity,
    output logic                  o_beat,
    output logic [HOLD_W-1:0]     o_hold_time
);

    localparam longint SCALE_MAG = ((64'sd10 <<< FRAC_BITS) + 64'sd45) / 64'sd91;
    localparam longint A1_MAG =
        ((64'sd17903124146 <<< FRAC_BITS) + 64'sd5000000000) / 64'sd10000000000;
    localparam longint A2_MAG =
        ((64'sd7960060012 <<< FRAC_BITS) + 64'sd5000000000) / 64'sd10000000000;
    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    localparam int X_W    = SAMPLE_W + 1;
    localparam int XP_W   = (X_W + FRAC_BITS > HIST_W + 1) ? X_W + FRAC_BITS : HIST_W + 1;
    localparam int CO_W   = FRAC_BITS + 2;
    localparam int PR_W   = HIST_W + CO_W;
    localparam int ACC_W  = PR_W + 1;
    localparam int SH_W   = ACC_W - FRAC_BITS;
    localparam int SUM_W  = SH_W + 2;
    localparam int MAG_W  = HIST_W + 1;
    localparam int TSH_W  = THR_W + FRAC_BITS;
    localparam int CMP_W  = (MAG_W > TSH_W) ? MAG_W : TSH_W;

    localparam logic signed [FRAC_BITS-1:0] SCALE_C = FRAC_BITS'(SCALE_MAG);
    localparam logic signed [CO_W-1:0]      COEF_A1 = CO_W'(A1_MAG);
    localparam logic signed [CO_W-1:0]      COEF_A2 = CO_W'(-A2_MAG);
    localparam logic [SAMPLE_W-1:0]         ADC_MASK = SAMPLE_W'((64'sd1 <<< ADC_BITS) - 1);

    localparam logic signed [XP_W-1:0]  XP_MAX  = XP_W'(64'sd2147483647);
    localparam logic signed [XP_W-1:0]  XP_MIN  = XP_W'(-64'sd2147483648);
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-64'sd2147483648);
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(ROUND_HALF);

    logic [SAMPLE_W-1:0] r_dc_offset;
    logic [THR_W-1:0]    r_beat_thr;
    logic [LEVEL_W-1:0]  r_peak_level;
    logic [HOLD_W-1:0]   r_beat_hold;
    logic [HOLD_W-1:0]   r_decay_hold;

    logic                r_a_valid;
    logic [SAMPLE_W-1:0] r_a_sample;
    logic                r_a_restart;

    logic                     r_b_valid;
    logic signed [HIST_W-1:0] r_b_xn;
    logic                     r_b_restart;

    logic signed [HIST_W-1:0] r_x1, r_x2, r_y1, r_y2;
    logic [LEVEL_W-1:0]       r_level;

    logic                r_o_valid;
    logic [LEVEL_W-1:0]  r_o_intensity;
    logic                r_o_beat;
    logic [HOLD_W-1:0]   r_o_hold_time;

    logic out_free, en_c, b_free, en_b, a_free;

    logic signed [X_W-1:0]    x_diff;
    logic signed [XP_W-1:0]   x_prod;
    logic signed [HIST_W-1:0] n_xn;

    logic signed [PR_W-1:0]   m_a2, m_a1;
    logic signed [ACC_W-1:0]  acc, acc_rnd;
    logic signed [SH_W-1:0]   acc_q;
    logic signed [SUM_W-1:0]  y_sum;
    logic signed [HIST_W-1:0] n_y;
    logic [MAG_W-1:0]         y_ext, y_mag;
    logic                     is_beat;
    logic [LEVEL_W-1:0]       lvl_in, n_level;
    logic                     has_result;

    // Handshake chain across the three stages.
    assign out_free = !r_o_valid || !i_stall;
    assign en_c     = r_b_valid && out_free;
    assign b_free   = !r_b_valid || en_c;
    assign en_b     = r_a_valid && b_free;
    assign a_free   = !r_a_valid || en_b;
    assign o_stall  = !a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_offset  <= DC_OFFSET_RST;
            r_beat_thr   <= BEAT_THR_RST;
            r_peak_level <= PEAK_LEVEL_RST;
            r_beat_hold  <= BEAT_HOLD_RST;
            r_decay_hold <= DECAY_HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DC_OFFSET:  r_dc_offset  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_BEAT_THR:   r_beat_thr   <= i_cfg_data[THR_W-1:0];
                CFG_PEAK_LEVEL: r_peak_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_BEAT_HOLD:  r_beat_hold  <= i_cfg_data[HOLD_W-1:0];
                CFG_DECAY_HOLD: r_decay_hold <= i_cfg_data[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && i_valid) begin
            r_a_sample  <= i_sample & ADC_MASK;
            r_a_restart <= i_restart;
        end
    end

    // Offset removal and scaling into fixed point.
    assign x_diff = $signed({1'b0, r_a_sample}) - $signed({1'b0, r_dc_offset});
    assign x_prod = XP_W'(x_diff) * XP_W'(SCALE_C);

    always_comb begin
        if (x_prod > XP_MAX) begin
            n_xn = HIST_W'(XP_MAX);
        end else if (x_prod < XP_MIN) begin
            n_xn = HIST_W'(XP_MIN);
        end else begin
            n_xn = x_prod[HIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= en_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_xn      <= n_xn;
            r_b_restart <= r_a_restart;
        end
    end

    // Filter recursion, saturation and beat decision.
    assign m_a2    = PR_W'(COEF_A2) * PR_W'(r_y2);
    assign m_a1    = PR_W'(COEF_A1) * PR_W'(r_y1);
    assign acc     = ACC_W'(m_a2) + ACC_W'(m_a1);
    assign acc_rnd = acc + ACC_HALF;
    assign acc_q   = acc_rnd[ACC_W-1:FRAC_BITS];
    assign y_sum   = SUM_W'(r_b_xn) - SUM_W'(r_x2) + SUM_W'(acc_q);

    always_comb begin
        if (y_sum > SUM_MAX) begin
            n_y = HIST_W'(SUM_MAX);
        end else if (y_sum < SUM_MIN) begin
            n_y = HIST_W'(SUM_MIN);
        end else begin
            n_y = y_sum[HIST_W-1:0];
        end
    end

    assign y_ext   = {n_y[HIST_W-1], n_y};
    assign y_mag   = n_y[HIST_W-1] ? (~y_ext + MAG_W'(1)) : y_ext;
    assign is_beat = CMP_W'(y_mag) > CMP_W'({r_beat_thr, {FRAC_BITS{1'b0}}});
    assign lvl_in  = r_b_restart ? '0 : r_level;

    always_comb begin
        if (is_beat) begin
            n_level    = r_peak_level;
            has_result = 1'b1;
        end else if (lvl_in != '0) begin
            n_level    = lvl_in - LEVEL_W'(1);
            has_result = 1'b1;
        end else begin
            n_level    = '0;
            has_result = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1    <= '0;
            r_x2    <= '0;
            r_y1    <= '0;
            r_y2    <= '0;
            r_level <= '0;
        end else if (en_c) begin
            r_x1    <= r_b_xn;
            r_x2    <= r_x1;
            r_y1    <= n_y;
            r_y2    <= r_y1;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= en_c && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && has_result) begin
            r_o_intensity <= n_level;
            r_o_beat      <= is_beat;
            r_o_hold_time <= is_beat ? r_beat_hold : r_decay_hold;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_intensity = r_o_intensity;
    assign o_beat      = r_o_beat;
    assign o_hold_time = r_o_hold_time;

endmodule

// File: hdl/abd_chk.sv
// ----------------------------------------------------------------------------
// abd_chk
// Port-level checks of the audio beat detector, bound to the top level.
// ----------------------------------------------------------------------------
module abd_chk
    import abd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [LEVEL_W-1:0]    o_intensity,
    input logic                  o_beat,
    input logic [HOLD_W-1:0]     o_hold_time
);

    // A stalled result item holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_intensity) && $stable(o_beat)
            && $stable(o_hold_time))
        else $error("stalled result item changed");

    // Reset leaves the pipe empty and ready.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipe not empty after reset");

    // The input side only backs up when the output side is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    // A decay step never wraps below zero.
    a_decay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_beat |-> o_intensity != {LEVEL_W{1'b1}})
        else $error("decay intensity wrapped");

endmodule

bind audio_beat_detector abd_chk u_abd_chk (.*);
